// ===== rtl/urlencoded_query_splitter_defines.svh =====
// assertion macros shared by the rtl files
`ifndef URLENCODED_QUERY_SPLITTER_DEFINES_SVH
`define URLENCODED_QUERY_SPLITTER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define UQS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define UQS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define UQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uqs_pkg.sv =====
package uqs_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] KIND_KEY     = 3'd0;
    localparam logic [2:0] KIND_VALUE   = 3'd1;
    localparam logic [2:0] KIND_KEPT    = 3'd2;
    localparam logic [2:0] KIND_DROPPED = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam int RES_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       run_last;
        logic       string_done;
    } result_t;

    // up to two results produced by one input word
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] num;
    } push_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    // valid only when is_hex holds; letters of both cases share the low nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic logic [2:0] end_kind(input logic in_value, input logic key_nonempty,
                                            input logic bad);
        logic [2:0] k;
        if (in_value && key_nonempty)
            k = bad ? KIND_ERROR : KIND_KEPT;
        else
            k = KIND_DROPPED;
        return k;
    endfunction

endpackage

// ===== rtl/uqs_parser.sv =====
module uqs_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      ch,
    input  logic            final_byte,
    output uqs_pkg::push_t  push
);
    import uqs_pkg::*;

    localparam logic [1:0] HEX_IDLE   = 2'd0;
    localparam logic [1:0] HEX_FIRST  = 2'd1;
    localparam logic [1:0] HEX_SECOND = 2'd2;

    logic       in_value_reg, in_value_next;
    logic [1:0] hex_phase_reg, hex_phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       key_nonempty_reg, key_nonempty_next;
    logic       pair_bad_reg, pair_bad_next;
    logic       failed_reg, failed_next;

    logic       hex_ok;
    logic [3:0] nib;
    logic       emit;
    logic [7:0] byte_d;
    logic [2:0] kind_d;
    logic [2:0] kind_m;
    logic       bad_n;
    push_t      push_c;

    assign hex_ok = is_hex(ch);
    assign nib    = hex_nibble(ch);

    always_comb
    begin
        in_value_next     = in_value_reg;
        hex_phase_next    = hex_phase_reg;
        high_nibble_next  = high_nibble_reg;
        key_nonempty_next = key_nonempty_reg;
        pair_bad_next     = pair_bad_reg;
        failed_next       = failed_reg;
        emit              = 1'b0;
        byte_d            = ch;
        kind_d            = in_value_reg ? KIND_VALUE : KIND_KEY;
        kind_m            = KIND_DROPPED;
        bad_n             = pair_bad_reg | (hex_phase_reg != HEX_IDLE);
        push_c            = '0;

        if (failed_reg)
        begin
            // swallow everything up to the end of the string
            if (final_byte)
            begin
                push_c.res0.kind = KIND_ERROR;
                push_c.num       = 2'd1;
            end
        end
        else if (ch == CH_AMP)
        begin
            kind_m            = end_kind(in_value_reg, key_nonempty_reg, bad_n);
            push_c.res0.kind  = kind_m;
            push_c.num        = 2'd1;
            in_value_next     = 1'b0;
            hex_phase_next    = HEX_IDLE;
            high_nibble_next  = 4'd0;
            key_nonempty_next = 1'b0;
            pair_bad_next     = 1'b0;
            failed_next       = (kind_m == KIND_ERROR);
        end
        else if (ch == CH_EQ && !in_value_reg)
        begin
            in_value_next    = 1'b1;
            hex_phase_next   = HEX_IDLE;
            high_nibble_next = 4'd0;
            pair_bad_next    = bad_n;
            if (final_byte)
            begin
                push_c.res0.kind = end_kind(1'b1, key_nonempty_reg, bad_n);
                push_c.num       = 2'd1;
            end
        end
        else
        begin
            key_nonempty_next = key_nonempty_reg | ~in_value_reg;
            if (hex_phase_reg == HEX_IDLE)
            begin
                if (ch == CH_PCT)
                    hex_phase_next = HEX_FIRST;
                else
                begin
                    emit   = 1'b1;
                    byte_d = (ch == CH_PLUS) ? CH_SPACE : ch;
                end
            end
            else if (!hex_ok)
            begin
                pair_bad_next    = 1'b1;
                hex_phase_next   = HEX_IDLE;
                high_nibble_next = 4'd0;
            end
            else if (hex_phase_reg == HEX_FIRST)
            begin
                high_nibble_next = nib;
                hex_phase_next   = HEX_SECOND;
            end
            else
            begin
                emit             = 1'b1;
                byte_d           = {high_nibble_reg, nib};
                hex_phase_next   = HEX_IDLE;
                high_nibble_next = 4'd0;
            end

            kind_m = end_kind(in_value_reg, key_nonempty_next,
                              pair_bad_next | (hex_phase_next != HEX_IDLE));
            if (emit)
            begin
                push_c.res0.out_byte = byte_d;
                push_c.res0.kind     = kind_d;
                push_c.res1.kind     = kind_m;
                push_c.num           = final_byte ? 2'd2 : 2'd1;
            end
            else if (final_byte)
            begin
                push_c.res0.kind = kind_m;
                push_c.num       = 2'd1;
            end
        end

        // end of string: start afresh with the next word
        if (final_byte)
        begin
            in_value_next     = 1'b0;
            hex_phase_next    = HEX_IDLE;
            high_nibble_next  = 4'd0;
            key_nonempty_next = 1'b0;
            pair_bad_next     = 1'b0;
            failed_next       = 1'b0;
        end

        if (push_c.num == 2'd1)
        begin
            push_c.res0.run_last    = 1'b1;
            push_c.res0.string_done = final_byte;
        end
        else if (push_c.num == 2'd2)
        begin
            push_c.res1.run_last    = 1'b1;
            push_c.res1.string_done = final_byte;
        end

        if (!fire)
            push_c.num = 2'd0;
    end

    assign push = push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg     <= 1'b0;
            hex_phase_reg    <= HEX_IDLE;
            high_nibble_reg  <= 4'd0;
            key_nonempty_reg <= 1'b0;
            pair_bad_reg     <= 1'b0;
            failed_reg       <= 1'b0;
        end
        else if (fire)
        begin
            in_value_reg     <= in_value_next;
            hex_phase_reg    <= hex_phase_next;
            high_nibble_reg  <= high_nibble_next;
            key_nonempty_reg <= key_nonempty_next;
            pair_bad_reg     <= pair_bad_next;
            failed_reg       <= failed_next;
        end
    end

endmodule

// ===== rtl/uqs_result_fifo.sv =====
`include "urlencoded_query_splitter_defines.svh"

module uqs_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  uqs_pkg::push_t   push,
    output logic             space_ok,
    output uqs_pkg::result_t head,
    output logic             head_valid,
    input  logic             pop
);
    import uqs_pkg::*;

    localparam int Depth = RES_FIFO_DEPTH;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);

    result_t         mem [Depth];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    // room for the worst case of two results per word
    assign space_ok   = (count_reg <= CW'(Depth - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + AW'(push.num);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push.num) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem[wr_ptr_reg] <= push.res0;
        if (push.num == 2'd2)
            mem[wr_ptr_reg + AW'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `UQS_ASSERT_ALWAYS(a_fifo_bound, count_reg <= CW'(Depth), "result fifo overflow")
    `UQS_ASSERT_IMPL(a_push_room, push.num != 2'd0, count_reg <= CW'(Depth - 2), "push without room")
    `UQS_ASSERT_NEXT(a_pop_only, pop && push.num == 2'd0, count_reg == $past(count_reg) - CW'(1), "pop count slip")

endmodule

// ===== rtl/urlencoded_query_splitter.sv =====
// URL query splitter: takes one raw query byte per clock while item_ready is high, with a flag on
// the last byte of the string, and returns decoded key and value words ('+' as space, %XY as one
// byte) plus one marker word per pair (kept, dropped or error). A byte is registered on entry,
// decoded from that register once the result queue has room, and written into a four-word
// result queue, from whose head its first result is offered. The decode step handles one byte
// per cycle while the result queue has room; a byte may produce up to two result words and the
// result port drains one word per cycle while result_ready is high, so the sustained input rate
// is one byte per cycle while each byte gives one result and falls below that when every byte
// gives two. item_ready drops only when the result queue cannot take two more words.
`include "urlencoded_query_splitter_defines.svh"

module urlencoded_query_splitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] ch,
    input  logic       final_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       run_last,
    output logic       string_done
);
    import uqs_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] ch_reg;
    logic       fin_reg;
    logic       space_ok;
    logic       s1_fire;
    logic       item_accept;
    push_t      push;
    result_t    head;

    assign s1_fire     = s1_valid_reg & space_ok;
    assign item_ready  = ~s1_valid_reg | space_ok;
    assign item_accept = item_valid & item_ready;

    assign s1_valid_next = item_accept | (s1_valid_reg & ~space_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            ch_reg  <= ch;
            fin_reg <= final_byte;
        end
    end

    uqs_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .ch         (ch_reg),
        .final_byte (fin_reg),
        .push       (push)
    );

    uqs_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space_ok   (space_ok),
        .head       (head),
        .head_valid (result_valid),
        .pop        (result_valid & result_ready)
    );

    assign out_byte    = head.out_byte;
    assign kind        = head.kind;
    assign run_last    = head.run_last;
    assign string_done = head.string_done;

    // markers carry no byte, and the end of a string always closes a word's results
    `UQS_ASSERT_IMPL(a_done_last, result_valid && string_done, run_last, "string_done without run_last")
    `UQS_ASSERT_IMPL(a_marker_zero, result_valid && kind != KIND_KEY && kind != KIND_VALUE, out_byte == 8'h00, "marker word with data")
    `UQS_ASSERT_IMPL(a_stall_held, !item_ready, s1_valid_reg && !s1_fire, "input stalled with empty stage")

endmodule

// ===== tb/sv/urlencoded_query_splitter_checker.sv =====
`timescale 1ns / 100ps

module urlencoded_query_splitter_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic [7:0] ch,
    input  logic       final_byte,
    input  logic       result_valid,
    input  logic       result_ready,
    input  logic [7:0] out_byte,
    input  logic [2:0] kind,
    input  logic       run_last,
    input  logic       string_done,
    output int         word_errors,
    output int         words_due
);
    import uqs_pkg::*;

    localparam logic [1:0] HEX_IDLE = 2'd0;
    localparam logic [1:0] HEX_PCT  = 2'd1;
    localparam logic [1:0] HEX_HIGH = 2'd2;

    // shadow of the splitter's parse state
    logic       in_value;
    logic [1:0] hex_phase;
    logic [3:0] high_nibble;
    logic       key_nonempty;
    logic       pair_bad;
    logic       failed;

    result_t    decoded_words[$];
    result_t    due;

    task automatic clear_pair();
        in_value     = 1'b0;
        hex_phase    = HEX_IDLE;
        high_nibble  = '0;
        key_nonempty = 1'b0;
        pair_bad     = 1'b0;
    endtask

    task automatic close_pair(output logic [2:0] marker);
        if (in_value && key_nonempty) begin
            if (pair_bad || hex_phase != HEX_IDLE) begin
                marker = KIND_ERROR;
                failed = 1'b1;
            end
            else
                marker = KIND_KEPT;
        end
        else
            marker = KIND_DROPPED;
        clear_pair();
    endtask

    task automatic decode_query_byte(input logic [7:0] c, input logic fin);
        result_t    words[2];
        int         n;
        int         i;
        logic [2:0] marker;
        logic [2:0] dk;
        logic [7:0] dv;
        logic       hex_ok;
        n        = 0;
        words[0] = '0;
        words[1] = '0;
        hex_ok   = 1'b1;
        if (c >= "0" && c <= "9")
            dv = c - "0";
        else if (c >= "A" && c <= "F")
            dv = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f")
            dv = c - "a" + 8'd10;
        else
        begin
            hex_ok = 1'b0;
            dv     = '0;
        end

        if (failed) begin
            // rest of the string is swallowed, the final byte repeats the error
            if (fin) begin
                words[0] = '{8'h00, KIND_ERROR, 1'b0, 1'b0};
                n        = 1;
            end
        end
        else if (c == CH_AMP) begin
            close_pair(marker);
            words[0] = '{8'h00, marker, 1'b0, 1'b0};
            n        = 1;
        end
        else if (c == CH_EQ && !in_value) begin
            if (hex_phase != HEX_IDLE)
                pair_bad = 1'b1;
            hex_phase   = HEX_IDLE;
            high_nibble = '0;
            in_value    = 1'b1;
            if (fin) begin
                close_pair(marker);
                words[0] = '{8'h00, marker, 1'b0, 1'b0};
                n        = 1;
            end
        end
        else
        begin
            dk = in_value ? KIND_VALUE : KIND_KEY;
            if (!in_value)
                key_nonempty = 1'b1;
            if (hex_phase == HEX_IDLE) begin
                if (c == CH_PCT)
                    hex_phase = HEX_PCT;
                else
                begin
                    words[n] = '{(c == CH_PLUS) ? CH_SPACE : c, dk, 1'b0, 1'b0};
                    n++;
                end
            end
            else if (!hex_ok) begin
                // bad digit ends the escape and is itself dropped
                pair_bad    = 1'b1;
                hex_phase   = HEX_IDLE;
                high_nibble = '0;
            end
            else if (hex_phase == HEX_PCT) begin
                high_nibble = dv[3:0];
                hex_phase   = HEX_HIGH;
            end
            else
            begin
                words[n] = '{{high_nibble, dv[3:0]}, dk, 1'b0, 1'b0};
                n++;
                hex_phase   = HEX_IDLE;
                high_nibble = '0;
            end
            if (fin) begin
                close_pair(marker);
                words[n] = '{8'h00, marker, 1'b0, 1'b0};
                n++;
            end
        end

        if (n > 0) begin
            words[n - 1].run_last = 1'b1;
            if (fin) begin
                words[n - 1].string_done = 1'b1;
                clear_pair();
                failed = 1'b0;
            end
        end
        for (i = 0; i < n; i++)
            decoded_words.push_back(words[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_pair();
            failed = 1'b0;
            decoded_words.delete();
            word_errors = 0;
            words_due   = 0;
        end
        else
        begin
            if (result_valid && result_ready) begin
                if (decoded_words.size() == 0) begin
                    word_errors++;
                    if (word_errors <= 10)
                        $display("unexpected word: byte %02h kind %0d last %0b done %0b",
                                 out_byte, kind, run_last, string_done);
                end
                else
                begin
                    due = decoded_words.pop_front();
                    if (out_byte !== due.out_byte || kind !== due.kind
                        || run_last !== due.run_last || string_done !== due.string_done) begin
                        word_errors++;
                        if (word_errors <= 10)
                            $display("word mismatch: expected byte %02h kind %0d last %0b ",
                                     due.out_byte, due.kind, due.run_last,
                                     "done %0b, got byte %02h kind %0d last %0b done %0b",
                                     due.string_done, out_byte, kind, run_last, string_done);
                    end
                end
            end
            if (item_valid && item_ready)
                decode_query_byte(ch, final_byte);
            words_due = decoded_words.size();
        end
    end

endmodule

// ===== tb/sv/tb_urlencoded_query_splitter.sv =====
`timescale 1ns / 100ps

module tb_urlencoded_query_splitter;
    import uqs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES    = 8;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    logic [7:0] ch           = '0;
    logic       final_byte   = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       run_last;
    logic       string_done;

    int         word_errors;
    int         words_due;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         bytes_sent     = 0;
    int         cycle_count    = 0;
    logic [7:0] query_buf[$];

    always #5 clk = ~clk;

    urlencoded_query_splitter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .kind         (kind),
        .run_last     (run_last),
        .string_done  (string_done)
    );

    urlencoded_query_splitter_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .ch           (ch),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .kind         (kind),
        .run_last     (run_last),
        .string_done  (string_done),
        .word_errors  (word_errors),
        .words_due    (words_due)
    );

    always @(posedge clk) begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL urlencoded_query_splitter");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [7:0] plain_byte();
        case ($urandom_range(9))
            0:       return CH_PLUS;
            1:       return 8'($urandom_range(255));
            2, 3:    return 8'("0" + $urandom_range(9));
            4:       return 8'("A" + $urandom_range(25));
            default: return 8'("a" + $urandom_range(25));
        endcase
    endfunction

    task automatic add_text(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            case ($urandom_range(39))
                0, 1, 2, 3, 4, 5:
                begin
                    query_buf.push_back(CH_PCT);
                    query_buf.push_back(hex_char(4'($urandom_range(15))));
                    query_buf.push_back(hex_char(4'($urandom_range(15))));
                end
                6:
                begin
                    // escape with a non-hex digit
                    query_buf.push_back(CH_PCT);
                    if ($urandom_range(1))
                        query_buf.push_back(hex_char(4'($urandom_range(15))));
                    query_buf.push_back(8'("g" + $urandom_range(19)));
                end
                7:
                begin
                    // escape cut short by whatever follows
                    query_buf.push_back(CH_PCT);
                    if ($urandom_range(1))
                        query_buf.push_back(hex_char(4'($urandom_range(15))));
                end
                default:
                    query_buf.push_back(plain_byte());
            endcase
        end
    endtask

    task automatic build_query();
        int pairs;
        int p;
        if ($urandom_range(9) < 2) begin
            // noise heavy in delimiters and escapes
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(5))
                    0:       query_buf.push_back(CH_AMP);
                    1:       query_buf.push_back(CH_EQ);
                    2:       query_buf.push_back(CH_PCT);
                    3:       query_buf.push_back(CH_PLUS);
                    4:       query_buf.push_back(hex_char(4'($urandom_range(15))));
                    default: query_buf.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            pairs = $urandom_range(1, 4);
            for (p = 0; p < pairs; p++) begin
                if (p > 0)
                    query_buf.push_back(CH_AMP);
                add_text(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
                if ($urandom_range(9) != 0)
                    query_buf.push_back(CH_EQ);
                add_text($urandom_range(0, 5));
            end
            if ($urandom_range(9) == 0)
                query_buf.push_back(CH_AMP);
        end
        if (query_buf.size() == 0)
            query_buf.push_back(plain_byte());
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            query_buf.push_back(s[i]);
    endtask

    task automatic send_word(input logic [7:0] c, input logic fin);
        if ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        ch         <= c;
        final_byte <= fin;
        do
            @(posedge clk);
        while (!item_ready);
        bytes_sent++;
    endtask

    task automatic send_query();
        int i;
        for (i = 0; i < query_buf.size(); i++)
            send_word(query_buf[i], i == query_buf.size() - 1);
        query_buf.delete();
    endtask

    initial begin
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escapes in both cases, plus as space, second equals sign in the value
        queue_text("k%4A=+=%7e");
        send_query();
        // bad escape in a dropped pair, key cut mid-escape, bytes after an error
        queue_text("a%zb&%=&q");
        send_query();
        // extreme byte values and a trailing ampersand
        query_buf.push_back(8'hFF);
        query_buf.push_back(CH_EQ);
        query_buf.push_back(8'h00);
        query_buf.push_back(CH_AMP);
        send_query();
        // escape cut off by the end of the string
        queue_text("x=%4");
        send_query();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            while (bytes_sent < (phase + 1) * ITEMS_PER_PHASE) begin
                build_query();
                send_query();
            end
        end
        item_valid <= 1'b0;

        @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (word_errors == 0 && words_due == 0)
            $display("PASS urlencoded_query_splitter");
        else
            $display("FAIL urlencoded_query_splitter");
        $finish;
    end

endmodule
